[sv/gre_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gre_pkg
// Shared types, constants and the 5x7 glyph ROM of the glyph row expander.
// ----------------------------------------------------------------------------
package gre_pkg;

    localparam int GLYPH_ROWS  = 7;
    localparam int CELL_WIDTH  = 6;
    localparam int MAX_SCALE   = 10;
    localparam int FONT_BITS   = 5;
    localparam int GLYPH_COUNT = 43;

    localparam int CODE_W  = 8;
    localparam int ROW_W   = 3;
    localparam int COLOR_W = 16;
    localparam int SCALE_W = 4;
    localparam int COL_W   = $clog2(CELL_WIDTH);
    localparam int SLOT_W  = $clog2(GLYPH_COUNT);
    localparam int CFG_IDX_W = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR    = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;
    localparam logic [COLOR_W-1:0] FG_RESET    = 16'hFFFF;
    localparam logic [COLOR_W-1:0] BG_RESET    = 16'h0000;

    localparam logic [CODE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CODE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CODE_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CODE_W-1:0] CHAR_Z     = 8'h5A;
    localparam logic [CODE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CODE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CODE_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CODE_W-1:0] CHAR_PCT   = 8'h25;
    localparam logic [CODE_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CODE_W-1:0] CHAR_SLASH = 8'h2F;

    localparam logic [SLOT_W-1:0] SLOT_BLANK  = 6'd0;
    localparam logic [SLOT_W-1:0] SLOT_DIGIT0 = 6'd1;
    localparam logic [SLOT_W-1:0] SLOT_LETTER = 6'd11;
    localparam logic [SLOT_W-1:0] SLOT_PLUS   = 6'd37;
    localparam logic [SLOT_W-1:0] SLOT_MINUS  = 6'd38;
    localparam logic [SLOT_W-1:0] SLOT_DOT    = 6'd39;
    localparam logic [SLOT_W-1:0] SLOT_PCT    = 6'd40;
    localparam logic [SLOT_W-1:0] SLOT_COLON  = 6'd41;
    localparam logic [SLOT_W-1:0] SLOT_SLASH  = 6'd42;

    typedef logic [FONT_BITS-1:0] t_row_bits;
    typedef logic [GLYPH_ROWS-1:0][FONT_BITS-1:0] t_glyph;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic [ROW_W-1:0]  font_row;
    } t_in_item;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic               lit;
        logic               last_pixel;
    } t_out_item;

    typedef struct packed {
        logic      push;
        t_row_bits bits;
    } t_q_write;

    typedef struct packed {
        logic      valid;
        t_row_bits bits;
    } t_q_read;

    function automatic logic [SLOT_W-1:0] rom_slot(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] off;
        off = '0;
        if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            off = code - CHAR_ZERO;
            return SLOT_DIGIT0 + off[SLOT_W-1:0];
        end
        if (code >= CHAR_A && code <= CHAR_Z) begin
            off = code - CHAR_A;
            return SLOT_LETTER + off[SLOT_W-1:0];
        end
        unique case (code)
            CHAR_PLUS:  return SLOT_PLUS;
            CHAR_MINUS: return SLOT_MINUS;
            CHAR_DOT:   return SLOT_DOT;
            CHAR_PCT:   return SLOT_PCT;
            CHAR_COLON: return SLOT_COLON;
            CHAR_SLASH: return SLOT_SLASH;
            default:    return SLOT_BLANK;
        endcase
    endfunction

    // Row 0 sits in the highest element of the packed glyph.
    function automatic t_glyph glyph_rom(input logic [SLOT_W-1:0] slot);
        unique case (slot)
            6'd1:  return {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
            6'd2:  return {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
            6'd3:  return {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
            6'd4:  return {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
            6'd5:  return {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
            6'd6:  return {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
            6'd7:  return {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
            6'd8:  return {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
            6'd9:  return {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
            6'd10: return {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
            6'd11: return {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
            6'd12: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
            6'd13: return {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
            6'd14: return {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
            6'd15: return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
            6'd16: return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
            6'd17: return {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
            6'd18: return {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
            6'd19: return {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
            6'd20: return {5'd7,  5'd2,  5'd2,  5'd2,  5'd2,  5'd18, 5'd12};
            6'd21: return {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
            6'd22: return {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
            6'd23: return {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
            6'd24: return {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
            6'd25: return {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
            6'd26: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
            6'd27: return {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
            6'd28: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
            6'd29: return {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
            6'd30: return {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
            6'd31: return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
            6'd32: return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
            6'd33: return {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
            6'd34: return {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
            6'd35: return {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
            6'd36: return {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
            6'd37: return {5'd4,  5'd4,  5'd31, 5'd4,  5'd4,  5'd0,  5'd0};
            6'd38: return {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
            6'd39: return {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
            6'd40: return {5'd17, 5'd2,  5'd4,  5'd8,  5'd17, 5'd0,  5'd0};
            6'd41: return {5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0};
            6'd42: return {5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd0,  5'd0};
            default: return '0;
        endcase
    endfunction

endpackage
`default_nettype wire

[sv/gre_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gre_front
// Accepts character rows, looks up the glyph and writes the row bits to the
// queue.
// ----------------------------------------------------------------------------
module gre_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire gre_pkg::t_in_item i_in,
    input  wire logic             i_q_full,
    output logic                  o_busy,
    output gre_pkg::t_q_write     o_q_wr
);

    gre_pkg::t_glyph             glyph;
    logic [gre_pkg::SLOT_W-1:0]  slot;
    logic [gre_pkg::ROW_W-1:0]   row_idx;

    always_comb begin
        slot    = gre_pkg::rom_slot(i_in.char_code);
        glyph   = gre_pkg::glyph_rom(slot);
        row_idx = gre_pkg::ROW_W'(gre_pkg::GLYPH_ROWS - 1) - i_in.font_row;
    end

    assign o_busy = i_q_full;

    always_comb begin
        o_q_wr.push = i_start && !i_q_full;
        if (i_in.font_row < gre_pkg::ROW_W'(gre_pkg::GLYPH_ROWS)) begin
            o_q_wr.bits = glyph[row_idx];
        end else begin
            o_q_wr.bits = '0;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_wr.push |-> !o_busy)
        else $error("front pushed while busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.font_row == gre_pkg::ROW_W'(gre_pkg::GLYPH_ROWS)) |-> (o_q_wr.bits == '0))
        else $error("row past the glyph gave lit bits");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_q_full) |-> o_q_wr.push)
        else $error("accepted row not pushed");

endmodule
`default_nettype wire

[sv/gre_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gre_queue
// Two-entry queue of glyph row bits between the front and the pixel
// sequencer.
// ----------------------------------------------------------------------------
module gre_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gre_pkg::t_q_write i_wr,
    input  wire logic              i_pop,
    output gre_pkg::t_q_read       o_rd,
    output logic                   o_full
);

    gre_pkg::t_row_bits            r_mem [gre_pkg::Q_DEPTH];
    logic [gre_pkg::Q_AW-1:0]      r_wptr, n_wptr;
    logic [gre_pkg::Q_AW-1:0]      r_rptr, n_rptr;
    logic [gre_pkg::Q_CW-1:0]      r_count, n_count;
    logic                          do_pop;

    assign do_pop    = i_pop && (r_count != '0);
    assign o_full    = (r_count == gre_pkg::Q_CW'(gre_pkg::Q_DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.bits  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_wr.push) begin
            n_wptr = (r_wptr == gre_pkg::Q_AW'(gre_pkg::Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == gre_pkg::Q_AW'(gre_pkg::Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_wr.push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr.push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wptr] <= i_wr.bits;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_wr.push)
        else $error("write into a full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= gre_pkg::Q_CW'(gre_pkg::Q_DEPTH))
        else $error("queue count overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && r_count == '0) |=> (r_count == $past(i_wr.push ? 2'd1 : 2'd0)))
        else $error("pop of an empty queue changed the count");

endmodule
`default_nettype wire

[sv/gre_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gre_back
// Pixel sequencer: walks the six cell columns of a glyph row, repeats each
// column by the scale and drives one pixel beat per cycle. Holds the
// configuration registers.
// ----------------------------------------------------------------------------
module gre_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [gre_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gre_pkg::COLOR_W-1:0]      i_cfg_data,
    output logic                                  o_cfg_ready,
    input  wire gre_pkg::t_q_read                 i_q_rd,
    output logic                                  o_pop,
    output logic                                  o_res_valid,
    output gre_pkg::t_out_item                    o_res
);

    logic [gre_pkg::SCALE_W-1:0] r_scale;
    logic [gre_pkg::COLOR_W-1:0] r_fg;
    logic [gre_pkg::COLOR_W-1:0] r_bg;

    logic                        r_active, n_active;
    gre_pkg::t_row_bits          r_bits, n_bits;
    logic [gre_pkg::COL_W-1:0]   r_col, n_col;
    logic [gre_pkg::SCALE_W-1:0] r_rep, n_rep;
    logic                        r_out_valid, n_out_valid;
    gre_pkg::t_out_item          r_out, n_out;

    logic [gre_pkg::SCALE_W-1:0] scale_eff;
    logic                        col_end;
    logic                        row_end;
    logic                        on;
    logic [gre_pkg::COL_W-1:0]   bit_idx;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= gre_pkg::SCALE_RESET;
            r_fg    <= gre_pkg::FG_RESET;
            r_bg    <= gre_pkg::BG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gre_pkg::CFG_PIXEL_SCALE: r_scale <= i_cfg_data[gre_pkg::SCALE_W-1:0];
                gre_pkg::CFG_FG_COLOR:    r_fg    <= i_cfg_data;
                gre_pkg::CFG_BG_COLOR:    r_bg    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_scale == '0) begin
            scale_eff = gre_pkg::SCALE_W'(1);
        end else if (r_scale > gre_pkg::SCALE_W'(gre_pkg::MAX_SCALE)) begin
            scale_eff = gre_pkg::SCALE_W'(gre_pkg::MAX_SCALE);
        end else begin
            scale_eff = r_scale;
        end
        col_end = (r_rep == scale_eff - 1'b1);
        row_end = col_end && (r_col == gre_pkg::COL_W'(gre_pkg::CELL_WIDTH - 1));
        bit_idx = gre_pkg::COL_W'(gre_pkg::FONT_BITS - 1) - r_col;
        on      = (r_col < gre_pkg::COL_W'(gre_pkg::FONT_BITS)) && r_bits[bit_idx];
    end

    assign o_pop = i_q_rd.valid && (!r_active || row_end);

    always_comb begin
        n_active    = r_active;
        n_bits      = r_bits;
        n_col       = r_col;
        n_rep       = r_rep;
        n_out_valid = r_active;
        n_out.pixel_color = on ? r_fg : r_bg;
        n_out.lit         = on;
        n_out.last_pixel  = row_end;
        if (r_active) begin
            if (col_end) begin
                n_rep = '0;
                n_col = r_col + 1'b1;
            end else begin
                n_rep = r_rep + 1'b1;
            end
            if (row_end) begin
                n_active = 1'b0;
            end
        end
        if (o_pop) begin
            n_active = 1'b1;
            n_bits   = i_q_rd.bits;
            n_col    = '0;
            n_rep    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_rep       <= '0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_col       <= n_col;
            r_rep       <= n_rep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_out  <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_active)
        else $error("sequencer idle after loading a row");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_active) |-> (r_out_valid && r_out.last_pixel))
        else $error("sequencer stopped before the last pixel");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.lit) |-> (r_out.pixel_color == $past(r_fg)))
        else $error("lit pixel without the foreground color");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_col < gre_pkg::COL_W'(gre_pkg::CELL_WIDTH)))
        else $error("column counter past the cell");

endmodule
`default_nettype wire

[sv/glyph_row_pixel_expander.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_row_pixel_expander
// 5x7 character generator: turns one glyph row of a character into a run of
// RGB565 pixels, each font column repeated by the pixel scale.
// ----------------------------------------------------------------------------
// Channel   Ports                                     Handshake
// input     i_start, o_busy, i_in                     beat when i_start && !o_busy
// config    i_cfg_valid, o_cfg_ready, i_cfg_index,    beat when valid && ready
//           i_cfg_data
// result    o_res_valid, o_res                        one beat per strobe cycle
//
// A row gives 6 * scale pixel beats, 6 to 60 of them, one per cycle from the pixel
// sequencer; rows in the queue follow with no gap.
// First pixel passes the row queue, sequencer row register and output register.
// o_busy rises while the two-entry row queue is full; results cannot stall.
// Reset is synchronous and restores scale 1, white foreground, black background.
// ----------------------------------------------------------------------------
module glyph_row_pixel_expander (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire gre_pkg::t_in_item             i_in,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [gre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [gre_pkg::COLOR_W-1:0]   i_cfg_data,
    output logic                               o_res_valid,
    output gre_pkg::t_out_item                 o_res
);

    gre_pkg::t_q_write q_wr;
    gre_pkg::t_q_read  q_rd;
    logic              q_full;
    logic              q_pop;

    gre_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_busy   (o_busy),
        .o_q_wr   (q_wr)
    );

    gre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_rd    (q_rd),
        .o_full  (q_full)
    );

    gre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_q_rd      (q_rd),
        .o_pop       (q_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire

[tb/glyph_row_pixel_expander_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_row_pixel_expander_tb
// Drives character rows into the 5x7 glyph expander and checks every pixel
// beat against a row predictor built into the bench. Directed rows cover the
// reset registers, every glyph group, unknown codes, the out-of-range row and
// the scale limits. Random rows then run under changing register settings and
// three sender idle rates.
// ----------------------------------------------------------------------------
module glyph_row_pixel_expander_tb;

    localparam logic [gre_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_start;
    logic                          o_busy;
    gre_pkg::t_in_item             i_in;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [gre_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [gre_pkg::COLOR_W-1:0]   i_cfg_data;
    logic                          o_res_valid;
    gre_pkg::t_out_item            o_res;

    logic [gre_pkg::SCALE_W-1:0] cur_scale;
    logic [gre_pkg::COLOR_W-1:0] cur_fg;
    logic [gre_pkg::COLOR_W-1:0] cur_bg;
    gre_pkg::t_out_item          pixel_expect[$];

    int fail_count     = 0;
    int rows_sent      = 0;
    int pixels_checked = 0;
    int config_writes  = 0;
    int send_idle_pct  = 0;

    logic [gre_pkg::CODE_W-1:0] punct_codes [6] = '{
        gre_pkg::CHAR_PLUS, gre_pkg::CHAR_MINUS, gre_pkg::CHAR_DOT,
        gre_pkg::CHAR_PCT, gre_pkg::CHAR_COLON, gre_pkg::CHAR_SLASH};

    int glyph_font [gre_pkg::GLYPH_COUNT][gre_pkg::GLYPH_ROWS] = '{
        '{0, 0, 0, 0, 0, 0, 0},
        '{14, 17, 19, 21, 25, 17, 14},
        '{4, 12, 4, 4, 4, 4, 14},
        '{14, 17, 1, 2, 4, 8, 31},
        '{30, 1, 1, 14, 1, 1, 30},
        '{2, 6, 10, 18, 31, 2, 2},
        '{31, 16, 16, 30, 1, 1, 30},
        '{14, 16, 16, 30, 17, 17, 14},
        '{31, 1, 2, 4, 8, 8, 8},
        '{14, 17, 17, 14, 17, 17, 14},
        '{14, 17, 17, 15, 1, 1, 14},
        '{14, 17, 17, 31, 17, 17, 17},
        '{30, 17, 17, 30, 17, 17, 30},
        '{14, 17, 16, 16, 16, 17, 14},
        '{30, 17, 17, 17, 17, 17, 30},
        '{31, 16, 16, 30, 16, 16, 31},
        '{31, 16, 16, 30, 16, 16, 16},
        '{14, 17, 16, 23, 17, 17, 15},
        '{17, 17, 17, 31, 17, 17, 17},
        '{14, 4, 4, 4, 4, 4, 14},
        '{7, 2, 2, 2, 2, 18, 12},
        '{17, 18, 20, 24, 20, 18, 17},
        '{16, 16, 16, 16, 16, 16, 31},
        '{17, 27, 21, 21, 17, 17, 17},
        '{17, 25, 21, 19, 17, 17, 17},
        '{14, 17, 17, 17, 17, 17, 14},
        '{30, 17, 17, 30, 16, 16, 16},
        '{14, 17, 17, 17, 21, 18, 13},
        '{30, 17, 17, 30, 20, 18, 17},
        '{15, 16, 16, 14, 1, 1, 30},
        '{31, 4, 4, 4, 4, 4, 4},
        '{17, 17, 17, 17, 17, 17, 14},
        '{17, 17, 17, 17, 17, 10, 4},
        '{17, 17, 17, 21, 21, 21, 10},
        '{17, 17, 10, 4, 10, 17, 17},
        '{17, 17, 10, 4, 4, 4, 4},
        '{31, 1, 2, 4, 8, 16, 31},
        '{4, 4, 31, 4, 4, 0, 0},
        '{0, 0, 0, 31, 0, 0, 0},
        '{0, 0, 0, 0, 0, 12, 12},
        '{17, 2, 4, 8, 17, 0, 0},
        '{0, 12, 12, 0, 12, 12, 0},
        '{1, 2, 4, 8, 16, 0, 0}
    };

    glyph_row_pixel_expander uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    always #6 i_clk = ~i_clk;

    function automatic void predict_row(input gre_pkg::t_in_item beat);
        int                 slot;
        int                 eff;
        int                 bits;
        int                 total;
        int                 n;
        bit                 on;
        gre_pkg::t_out_item px;
        slot = int'(gre_pkg::SLOT_BLANK);
        if (beat.char_code >= gre_pkg::CHAR_ZERO && beat.char_code <= gre_pkg::CHAR_NINE) begin
            slot = int'(gre_pkg::SLOT_DIGIT0) + int'(beat.char_code - gre_pkg::CHAR_ZERO);
        end else if (beat.char_code >= gre_pkg::CHAR_A && beat.char_code <= gre_pkg::CHAR_Z) begin
            slot = int'(gre_pkg::SLOT_LETTER) + int'(beat.char_code - gre_pkg::CHAR_A);
        end else begin
            case (beat.char_code)
                gre_pkg::CHAR_PLUS:  slot = int'(gre_pkg::SLOT_PLUS);
                gre_pkg::CHAR_MINUS: slot = int'(gre_pkg::SLOT_MINUS);
                gre_pkg::CHAR_DOT:   slot = int'(gre_pkg::SLOT_DOT);
                gre_pkg::CHAR_PCT:   slot = int'(gre_pkg::SLOT_PCT);
                gre_pkg::CHAR_COLON: slot = int'(gre_pkg::SLOT_COLON);
                gre_pkg::CHAR_SLASH: slot = int'(gre_pkg::SLOT_SLASH);
                default:             slot = int'(gre_pkg::SLOT_BLANK);
            endcase
        end
        eff = int'(cur_scale);
        if (eff == 0) begin
            eff = 1;
        end
        if (eff > gre_pkg::MAX_SCALE) begin
            eff = gre_pkg::MAX_SCALE;
        end
        bits = (beat.font_row < gre_pkg::GLYPH_ROWS) ? glyph_font[slot][beat.font_row] : 0;
        total = gre_pkg::CELL_WIDTH * eff;
        n = 0;
        for (int col = 0; col < gre_pkg::CELL_WIDTH; col++) begin
            on = (col < gre_pkg::FONT_BITS) &&
                 (((bits >> (gre_pkg::FONT_BITS - 1 - col)) & 1) != 0);
            for (int rep = 0; rep < eff; rep++) begin
                px.pixel_color = on ? cur_fg : cur_bg;
                px.lit         = on;
                px.last_pixel  = (n == total - 1);
                pixel_expect.push_back(px);
                n++;
            end
        end
    endfunction

    always @(posedge i_clk) begin : pixel_checker
        gre_pkg::t_out_item want;
        if (i_rst_n && o_res_valid) begin
            if (pixel_expect.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected pixel beat, expected none, actual %h/%b/%b",
                         $time, o_res.pixel_color, o_res.lit, o_res.last_pixel);
            end else begin
                want = pixel_expect.pop_front();
                pixels_checked++;
                if (o_res.pixel_color !== want.pixel_color) begin
                    fail_count++;
                    $display("%0t: pixel_color expected %h actual %h",
                             $time, want.pixel_color, o_res.pixel_color);
                end
                if (o_res.lit !== want.lit) begin
                    fail_count++;
                    $display("%0t: lit expected %b actual %b", $time, want.lit, o_res.lit);
                end
                if (o_res.last_pixel !== want.last_pixel) begin
                    fail_count++;
                    $display("%0t: last_pixel expected %b actual %b",
                             $time, want.last_pixel, o_res.last_pixel);
                end
            end
        end
    end

    task automatic send_char_row(input logic [gre_pkg::CODE_W-1:0] code,
                                 input logic [gre_pkg::ROW_W-1:0] row);
        gre_pkg::t_in_item beat;
        beat.char_code = code;
        beat.font_row  = row;
        while ($urandom_range(99) < send_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in    <= beat;
        do @(posedge i_clk); while (o_busy);
        predict_row(beat);
        rows_sent++;
    endtask

    task automatic wait_for_idle();
        i_start <= 1'b0;
        while (pixel_expect.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_config(input logic [gre_pkg::CFG_IDX_W-1:0] idx,
                                input logic [gre_pkg::COLOR_W-1:0] data);
        wait_for_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            gre_pkg::CFG_PIXEL_SCALE: cur_scale = data[gre_pkg::SCALE_W-1:0];
            gre_pkg::CFG_FG_COLOR:    cur_fg    = data;
            gre_pkg::CFG_BG_COLOR:    cur_bg    = data;
            default:                  ;
        endcase
        config_writes++;
    endtask

    task automatic test_reset_defaults();
        send_char_row(gre_pkg::CHAR_ZERO, 3'd0);
        send_char_row(gre_pkg::CHAR_Z, 3'd6);
    endtask

    task automatic test_glyph_coverage();
        write_config(gre_pkg::CFG_PIXEL_SCALE, 16'h0002);
        write_config(gre_pkg::CFG_FG_COLOR, 16'hF800);
        write_config(gre_pkg::CFG_BG_COLOR, 16'h07E0);
        send_char_row(gre_pkg::CHAR_NINE, 3'd3);
        send_char_row(gre_pkg::CHAR_A, 3'd3);
        for (int k = 0; k < 6; k++) begin
            send_char_row(punct_codes[k], gre_pkg::ROW_W'(k));
        end
        send_char_row(8'h00, 3'd5);
        send_char_row(8'hFF, 3'd2);
        send_char_row(8'h80, 3'd0);
        send_char_row(gre_pkg::CHAR_A + 8'd12, 3'd7);
        send_char_row(gre_pkg::CHAR_ZERO + 8'd8, 3'd7);
    endtask

    task automatic test_scale_limits();
        write_config(gre_pkg::CFG_PIXEL_SCALE, 16'h0000);
        send_char_row(gre_pkg::CHAR_A + 8'd22, 3'd3);
        write_config(gre_pkg::CFG_PIXEL_SCALE, 16'hFFFF);
        send_char_row(gre_pkg::CHAR_A + 8'd7, 3'd3);
        write_config(gre_pkg::CFG_PIXEL_SCALE, 16'h000B);
        send_char_row(gre_pkg::CHAR_A + 8'd23, 3'd0);
        write_config(gre_pkg::CFG_PIXEL_SCALE, 16'h000A);
        write_config(CFG_UNMAPPED, 16'h0005);
        send_char_row(gre_pkg::CHAR_A + 8'd14, 3'd0);
        write_config(gre_pkg::CFG_FG_COLOR, 16'h0000);
        write_config(gre_pkg::CFG_BG_COLOR, 16'hFFFF);
        write_config(gre_pkg::CFG_PIXEL_SCALE, 16'hFFF1);
        send_char_row(gre_pkg::CHAR_A + 8'd4, 3'd0);
        write_config(gre_pkg::CFG_FG_COLOR, 16'hA5A5);
        write_config(gre_pkg::CFG_BG_COLOR, 16'hA5A5);
        send_char_row(gre_pkg::CHAR_A + 8'd8, 3'd1);
    endtask

    task automatic test_random_rows(input int idle_pct, input int count);
        int                          pick;
        logic [gre_pkg::CODE_W-1:0]  code;
        logic [gre_pkg::ROW_W-1:0]   row;
        logic [gre_pkg::COLOR_W-1:0] data;
        send_idle_pct = idle_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 19 == 0) begin
                pick = $urandom_range(9);
                data = gre_pkg::COLOR_W'($urandom_range(16'hFFFF));
                if (pick <= 5) begin
                    data[gre_pkg::SCALE_W-1:0] = gre_pkg::SCALE_W'($urandom_range(1, 3));
                end else if (pick == 6) begin
                    data[gre_pkg::SCALE_W-1:0] = '0;
                end else if (pick == 7) begin
                    data[gre_pkg::SCALE_W-1:0] = gre_pkg::SCALE_W'($urandom_range(10, 15));
                end else begin
                    data[gre_pkg::SCALE_W-1:0] = gre_pkg::SCALE_W'($urandom_range(4, 9));
                end
                write_config(gre_pkg::CFG_PIXEL_SCALE, data);
                write_config(gre_pkg::CFG_FG_COLOR,
                             gre_pkg::COLOR_W'($urandom_range(16'hFFFF)));
                write_config(gre_pkg::CFG_BG_COLOR,
                             gre_pkg::COLOR_W'($urandom_range(16'hFFFF)));
                if ($urandom_range(3) == 0) begin
                    write_config(CFG_UNMAPPED, gre_pkg::COLOR_W'($urandom_range(16'hFFFF)));
                end
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                pick = $urandom_range(41);
                if (pick < 10) begin
                    code = gre_pkg::CHAR_ZERO + gre_pkg::CODE_W'(pick);
                end else if (pick < 36) begin
                    code = gre_pkg::CHAR_A + gre_pkg::CODE_W'(pick - 10);
                end else begin
                    code = punct_codes[pick - 36];
                end
            end else begin
                code = gre_pkg::CODE_W'($urandom_range(255));
            end
            row = ($urandom_range(9) == 0) ? 3'd7 : gre_pkg::ROW_W'($urandom_range(6));
            send_char_row(code, row);
        end
    endtask

    initial begin
        #(3_000_000);
        $display("FAIL glyph_row_pixel_expander");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        cur_scale = gre_pkg::SCALE_RESET;
        cur_fg    = gre_pkg::FG_RESET;
        cur_bg    = gre_pkg::BG_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 9;
        test_reset_defaults();
        test_glyph_coverage();
        test_scale_limits();
        test_random_rows(9, 50);
        test_random_rows(75, 50);
        test_random_rows(0, 50);

        wait_for_idle();
        repeat (80) @(posedge i_clk);

        $display("Drew %0d character rows, checked %0d pixel beats, made %0d register writes.",
                 rows_sent, pixels_checked, config_writes);
        $display("Covered reset values, all glyph groups, unknown codes, row 7 and scale clamps.");
        if (fail_count == 0) begin
            $display("PASS glyph_row_pixel_expander");
        end else begin
            $display("FAIL glyph_row_pixel_expander");
        end
        $finish;
    end

endmodule

[sim.f]
sv/gre_pkg.sv
sv/gre_front.sv
sv/gre_queue.sv
sv/gre_back.sv
sv/glyph_row_pixel_expander.sv
tb/glyph_row_pixel_expander_tb.sv
